// ===== hdl/sle_pkg.sv =====
// ---------------------------------------------------------------------------
// sle_pkg: shared types and constants for the serial line editor
// Character codes, result kinds, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package sle_pkg;

   localparam int LINE_MAX = 16;
   localparam int CUR_W    = $clog2(LINE_MAX);

   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_DEL    = 8'h7f;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_TILDE  = 8'h7e;
   localparam logic [7:0] CH_CTRL_W = 8'h17;
   localparam logic [7:0] CH_CTRL_U = 8'h15;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   localparam logic [3:0] STEP_CR     = 4'd0;
   localparam logic [3:0] STEP_LF     = 4'd1;
   localparam logic [3:0] STEP_RUB_SP = 4'd1;
   localparam logic [3:0] STEP_RUB_BS = 4'd2;
   localparam logic [3:0] STEP_ERR_LAST = 4'd12;

   typedef enum logic [2:0] {
      CLS_NEWLINE,
      CLS_BS,
      CLS_WERASE,
      CLS_KILL,
      CLS_TAB,
      CLS_PRINT,
      CLS_ERROR
   } cls_type;

   typedef enum logic [2:0] {
      SEL_BS,
      SEL_SP,
      SEL_CR,
      SEL_LF,
      SEL_CHAR,
      SEL_ERRTXT,
      SEL_DONE,
      SEL_READ
   } sel_type;

   typedef enum logic [2:0] {
      FIN_HOLD,
      FIN_PTR,
      FIN_DEC,
      FIN_INC,
      FIN_ZERO,
      FIN_TAB
   } fin_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CHAR,
      ST_NL,
      ST_ERR,
      ST_SCAN_SP,
      ST_SCAN_WORD,
      ST_ERASE,
      ST_TAB,
      ST_TAB_END
   } state_type;

   typedef struct packed {
      logic       take;
      logic       emit;
      sel_type    sel;
      logic       last;
      logic       ptr_dec;
      logic       ptr_inc;
      logic       ptr_load_cur;
      logic       b1_load;
      fin_op_type fin_op;
      logic       wr_char;
      logic       wr_space;
      logic       step_clr;
      logic       step_inc;
      logic       commit;
      logic       set_ended;
   } cmd_type;

   typedef struct packed {
      logic       op_read;
      cls_type    cls;
      logic       ptr_zero;
      logic       prev_space;
      logic       ptr_above_b1;
      logic       ptr_dec_fin;
      logic       ptr_inc_fin;
      logic       ptr_eq_cur;
      logic       fin_full;
      logic [3:0] step;
      logic       out_free;
   } sts_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v > 4'd9) begin
         r = 8'(v) - 8'd10 + 8'h41;
      end else begin
         r = 8'(v) + 8'h30;
      end
      return r;
   endfunction

   // error report: CR LF "ERROR: " hi lo CR LF
   function automatic logic [7:0] err_byte(input logic [3:0] step, input logic [7:0] c);
      logic [7:0] r;
      case (step)
         4'd0:    r = CH_CR;
         4'd1:    r = CH_LF;
         4'd2:    r = 8'h45;
         4'd3:    r = 8'h52;
         4'd4:    r = 8'h52;
         4'd5:    r = 8'h4f;
         4'd6:    r = 8'h52;
         4'd7:    r = 8'h3a;
         4'd8:    r = CH_SP;
         4'd9:    r = hex_digit(c[7:4]);
         4'd10:   r = hex_digit(c[3:0]);
         4'd11:   r = CH_CR;
         4'd12:   r = CH_LF;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/sle_ctrl.sv =====
// ---------------------------------------------------------------------------
// sle_ctrl: sequencer for the serial line editor
// Walks each request through decode, scan, and echo steps and drives the
// datapath one command bundle per cycle.
// ---------------------------------------------------------------------------
module sle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sle_pkg::sts_type sts,
   output sle_pkg::cmd_type cmd
);
   import sle_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.op_read) begin
               state_in = ST_READ;
            end else begin
               case (sts.cls)
                  CLS_NEWLINE: begin
                     cmd.step_clr = 1'b1;
                     state_in     = ST_NL;
                  end
                  CLS_ERROR: begin
                     cmd.step_clr = 1'b1;
                     state_in     = ST_ERR;
                  end
                  CLS_PRINT: begin
                     cmd.wr_char = 1'b1;
                     cmd.fin_op  = FIN_INC;
                     state_in    = ST_CHAR;
                  end
                  CLS_BS: begin
                     if (sts.ptr_zero) begin
                        state_in = ST_IDLE;
                     end else begin
                        cmd.b1_load  = 1'b1;
                        cmd.fin_op   = FIN_DEC;
                        cmd.step_clr = 1'b1;
                        state_in     = ST_ERASE;
                     end
                  end
                  CLS_KILL: begin
                     if (sts.ptr_zero) begin
                        state_in = ST_IDLE;
                     end else begin
                        cmd.b1_load  = 1'b1;
                        cmd.fin_op   = FIN_ZERO;
                        cmd.step_clr = 1'b1;
                        state_in     = ST_ERASE;
                     end
                  end
                  CLS_WERASE: begin
                     state_in = ST_SCAN_SP;
                  end
                  CLS_TAB: begin
                     cmd.fin_op = FIN_TAB;
                     state_in   = ST_TAB;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_READ;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CHAR: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.sel    = SEL_CHAR;
               cmd.last   = 1'b1;
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_NL: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.step_inc = 1'b1;
               if (sts.step == STEP_CR) begin
                  cmd.sel = SEL_CR;
               end else if (sts.step == STEP_LF) begin
                  cmd.sel = SEL_LF;
               end else begin
                  cmd.sel       = SEL_DONE;
                  cmd.last      = 1'b1;
                  cmd.set_ended = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = SEL_ERRTXT;
               cmd.step_inc = 1'b1;
               if (sts.step == STEP_ERR_LAST) begin
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN_SP: begin
            // back over trailing spaces
            if (!sts.ptr_zero && sts.prev_space) begin
               cmd.ptr_dec = 1'b1;
            end else begin
               cmd.b1_load = 1'b1;
               state_in    = ST_SCAN_WORD;
            end
         end
         ST_SCAN_WORD: begin
            if (!sts.ptr_zero && !sts.prev_space) begin
               cmd.ptr_dec = 1'b1;
            end else if (sts.ptr_eq_cur) begin
               state_in = ST_IDLE;
            end else begin
               cmd.fin_op       = FIN_PTR;
               cmd.ptr_load_cur = 1'b1;
               cmd.step_clr     = 1'b1;
               state_in         = ST_ERASE;
            end
         end
         ST_ERASE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.ptr_above_b1) begin
                  // space run: backspace only
                  cmd.sel     = SEL_BS;
                  cmd.ptr_dec = 1'b1;
                  if (sts.ptr_dec_fin) begin
                     cmd.last   = 1'b1;
                     cmd.commit = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end else begin
                  cmd.sel = (sts.step == STEP_RUB_SP) ? SEL_SP : SEL_BS;
                  if (sts.step == STEP_RUB_BS) begin
                     cmd.ptr_dec  = 1'b1;
                     cmd.step_clr = 1'b1;
                     if (sts.ptr_dec_fin) begin
                        cmd.last   = 1'b1;
                        cmd.commit = 1'b1;
                        state_in   = ST_IDLE;
                     end
                  end else begin
                     cmd.step_inc = 1'b1;
                  end
               end
            end
         end
         ST_TAB: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = SEL_SP;
               cmd.wr_space = 1'b1;
               cmd.ptr_inc  = 1'b1;
               if (sts.ptr_inc_fin) begin
                  if (sts.fin_full) begin
                     state_in = ST_TAB_END;
                  end else begin
                     cmd.last   = 1'b1;
                     cmd.commit = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
            end
         end
         ST_TAB_END: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = SEL_DONE;
               cmd.last      = 1'b1;
               cmd.commit    = 1'b1;
               cmd.set_ended = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/sle_datapath.sv =====
// ---------------------------------------------------------------------------
// sle_datapath: line store, cursor and result register
// Holds the request fields, the line store, the walk pointer and bounds,
// and the output register of the result channel.
// ---------------------------------------------------------------------------
module sle_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sle_pkg::cmd_type cmd,
   output sle_pkg::sts_type sts,
   input  logic             req_opcode,
   input  logic [7:0]       req_byte,
   input  logic             req_error,
   input  logic [3:0]       req_index,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data,
   output logic [3:0]       rsp_length,
   output logic             rsp_last
);
   import sle_pkg::*;

   localparam logic [CUR_W-1:0]   CUR_ONE  = CUR_W'(1);
   localparam logic [CUR_W-1:0]   CUR_TOP  = CUR_W'(LINE_MAX - 1);
   localparam logic [CUR_W+3:0]   WIDE_TOP = (CUR_W + 4)'(LINE_MAX - 1);

   logic [7:0]       store_ff [LINE_MAX];
   logic [CUR_W-1:0] cursor_ff;
   logic             ended_ff;
   logic             rsp_valid_ff;

   logic             op_ff;
   logic [7:0]       byte_ff;
   logic             err_ff;
   logic [3:0]       idx_ff;
   logic [CUR_W-1:0] ptr_ff;
   logic [CUR_W-1:0] b1_ff;
   logic [CUR_W-1:0] fin_ff;
   logic [3:0]       step_ff;
   logic [1:0]       kind_ff;
   logic [7:0]       data_ff;
   logic [3:0]       len_ff;
   logic             last_ff;

   logic [CUR_W-1:0] cur0;
   logic [CUR_W-1:0] ptr_m1;
   logic [CUR_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic [CUR_W+3:0] idx_w;
   logic [CUR_W+3:0] cur_w;
   logic             rd_hit;
   logic [CUR_W+3:0] tab_up;
   logic [CUR_W-1:0] tab_fin;
   logic [CUR_W-1:0] fin_in;
   logic [CUR_W+3:0] fin_w;
   logic             nl;
   cls_type          cls;
   logic [1:0]       kind_in;
   logic [7:0]       data_in;

   // start a new line if the previous one was completed
   assign cur0   = (req_opcode == OP_RECEIVE && ended_ff) ? '0 : cursor_ff;
   assign ptr_m1 = ptr_ff - CUR_ONE;
   assign idx_w  = {{CUR_W{1'b0}}, idx_ff};
   assign cur_w  = {4'b0, cursor_ff};
   assign rd_hit = idx_w < cur_w;
   assign rd_addr = (op_ff == OP_READ) ? idx_w[CUR_W-1:0] : ptr_m1;
   assign rd_data = store_ff[rd_addr];

   assign tab_up  = ({4'b0, ptr_ff} | (CUR_W + 4)'(7)) + (CUR_W + 4)'(1);
   assign tab_fin = (tab_up >= WIDE_TOP) ? CUR_TOP : tab_up[CUR_W-1:0];
   assign fin_w   = {4'b0, fin_ff};

   always_comb begin
      nl = err_ff || byte_ff == CH_CR || byte_ff == CH_ESC;
      if (cursor_ff >= CUR_TOP || nl) begin
         cls = CLS_NEWLINE;
      end else if (byte_ff == CH_BS || byte_ff == CH_DEL) begin
         cls = CLS_BS;
      end else if (byte_ff == CH_CTRL_W) begin
         cls = CLS_WERASE;
      end else if (byte_ff == CH_CTRL_U) begin
         cls = CLS_KILL;
      end else if (byte_ff == CH_TAB) begin
         cls = CLS_TAB;
      end else if (byte_ff inside {[CH_SP:CH_TILDE]}) begin
         cls = CLS_PRINT;
      end else begin
         cls = CLS_ERROR;
      end
   end

   always_comb begin
      sts.op_read      = (op_ff == OP_READ);
      sts.cls          = cls;
      sts.ptr_zero     = (ptr_ff == '0);
      sts.prev_space   = (rd_data == CH_SP);
      sts.ptr_above_b1 = (ptr_ff > b1_ff);
      sts.ptr_dec_fin  = (ptr_m1 == fin_ff);
      sts.ptr_inc_fin  = ({1'b0, ptr_ff} + (CUR_W + 1)'(1)) == {1'b0, fin_ff};
      sts.ptr_eq_cur   = (ptr_ff == cursor_ff);
      sts.fin_full     = (fin_ff >= CUR_TOP);
      sts.step         = step_ff;
      sts.out_free     = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      case (cmd.fin_op)
         FIN_PTR:  fin_in = ptr_ff;
         FIN_DEC:  fin_in = ptr_m1;
         FIN_INC:  fin_in = ptr_ff + CUR_ONE;
         FIN_ZERO: fin_in = '0;
         FIN_TAB:  fin_in = tab_fin;
         default:  fin_in = fin_ff;
      endcase
   end

   always_comb begin
      kind_in = KIND_ECHO;
      case (cmd.sel)
         SEL_BS:     data_in = CH_BS;
         SEL_SP:     data_in = CH_SP;
         SEL_CR:     data_in = CH_CR;
         SEL_LF:     data_in = CH_LF;
         SEL_CHAR:   data_in = byte_ff;
         SEL_ERRTXT: data_in = err_byte(step_ff, byte_ff);
         SEL_DONE: begin
            kind_in = KIND_LINE;
            data_in = 8'h00;
         end
         SEL_READ: begin
            kind_in = KIND_READ;
            data_in = rd_hit ? rd_data : 8'h00;
         end
         default:    data_in = 8'h00;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
         ended_ff     <= 1'b0;
         for (int i = 0; i < LINE_MAX; i++) begin
            store_ff[i] <= 8'h00;
         end
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.take && req_opcode == OP_RECEIVE) begin
            cursor_ff <= cur0;
            ended_ff  <= 1'b0;
         end else if (cmd.commit) begin
            cursor_ff <= fin_ff;
         end
         if (cmd.set_ended) begin
            ended_ff <= 1'b1;
         end
         if (cmd.wr_char) begin
            store_ff[ptr_ff] <= byte_ff;
         end else if (cmd.wr_space) begin
            store_ff[ptr_ff] <= CH_SP;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff   <= req_opcode;
         byte_ff <= req_byte;
         err_ff  <= req_error;
         idx_ff  <= req_index;
         ptr_ff  <= cur0;
         fin_ff  <= cur0;
      end else begin
         if (cmd.ptr_dec) begin
            ptr_ff <= ptr_m1;
         end else if (cmd.ptr_inc) begin
            ptr_ff <= ptr_ff + CUR_ONE;
         end else if (cmd.ptr_load_cur) begin
            ptr_ff <= cursor_ff;
         end
         fin_ff <= fin_in;
      end
      if (cmd.b1_load) begin
         b1_ff <= ptr_ff;
      end
      if (cmd.step_clr) begin
         step_ff <= 4'd0;
      end else if (cmd.step_inc) begin
         step_ff <= step_ff + 4'd1;
      end
      if (cmd.emit) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         len_ff  <= fin_w[3:0];
         last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_data   = data_ff;
   assign rsp_length = len_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== hdl/serial_line_editor.sv =====
// ---------------------------------------------------------------------------
// serial_line_editor: line editor over received UART bytes
// Stores and echoes printable characters, handles erase, word erase, line
// kill, tab and newline, reports bad bytes, and reads back the line store.
// ---------------------------------------------------------------------------
// Timing: the first result of a request is registered from the state after decode, or
//   after the word erase scan of one line store entry per cycle.
// Throughput: one result per cycle from one output register while rsp_tready is held;
//   a new request is taken only in idle, once the previous one is finished.
// Reset: synchronous; clears cursor, line-ended flag, line store and the
//   output valid; no clearing pass.
module serial_line_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rx_byte[7:0], read_index[11:8], zero[15:12]
   input  logic [1:0]  req_tuser,  // opcode[0], rx_error[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // data[7:0], line_length[11:8], zero[15:12]
   output logic [1:0]  rsp_tuser,  // kind[1:0]
   output logic        rsp_tlast
);
   import sle_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [7:0] rsp_data;
   logic [3:0] rsp_length;

   sle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sle_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_opcode (req_tuser[0]),
      .req_byte   (req_tdata[7:0]),
      .req_error  (req_tuser[1]),
      .req_index  (req_tdata[11:8]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_data   (rsp_data),
      .rsp_length (rsp_length),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, rsp_length, rsp_data};

endmodule
